### hw/rtl/ttp_pkg.sv
// shared types and constants for the tick task picker
// no dependencies; used by tick_task_picker_core and its checker
`timescale 1ns / 1ps

package ttp_pkg;

	localparam int TASKS  = 3;
	localparam int TASK_W = $clog2(TASKS);
	localparam int CD_W   = 16;
	localparam int CFG_W  = 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef logic [TASK_W-1:0] task_idx_t;
	typedef logic [CD_W-1:0]   count_t;
	typedef logic [CFG_W-1:0]  cfg_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WIN,
		ST_CHAL,
		ST_DISP
	} state_t;

	// register indexes, byte address is 4 * index
	typedef enum logic [2:0] {
		REG_DL0 = 3'd0,
		REG_DL1 = 3'd1,
		REG_DL2 = 3'd2,
		REG_RL0 = 3'd3,
		REG_RL1 = 3'd4,
		REG_RL2 = 3'd5
	} reg_idx_t;

endpackage

### hw/rtl/tick_task_picker_core.sv
// an accepted input beat runs match steps of the shared compare/decrement unit, one
// per cycle, then the dispatch step, which waits until the output register is free
// throughput: one tick at a time; in_ready is high only while the sequencer is idle
// a finished result waits in the output register while the next tick is taken
// reset (arst_n low, asynchronous): cooldowns, registers and control cleared
`timescale 1ns / 1ps

module tick_task_picker_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ttp_pkg::ADDR_W-1:0]    paddr,
	input  logic [ttp_pkg::DATA_W-1:0]    pwdata,
	output logic [ttp_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [ttp_pkg::TASKS-1:0]     ready_mask,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          ran,
	output logic [ttp_pkg::TASK_W-1:0]    task_index
);

	localparam int ADDR_MSB = ttp_pkg::ADDR_W - 1;

	ttp_pkg::cfg_t   deadline_q [ttp_pkg::TASKS];
	ttp_pkg::cfg_t   reload_q   [ttp_pkg::TASKS];
	ttp_pkg::count_t cd_q       [ttp_pkg::TASKS];

	ttp_pkg::state_t    state_q, state_n;
	ttp_pkg::task_idx_t win_q, win_n;
	ttp_pkg::task_idx_t ch_q, ch_n;
	ttp_pkg::cfg_t      win_dl_q, win_dl_n;
	logic [ttp_pkg::TASKS-1:0] mask_q;
	logic               out_valid_q;
	logic               ran_q;
	ttp_pkg::task_idx_t task_idx_q;

	ttp_pkg::task_idx_t cd_addr;
	ttp_pkg::count_t    cd_rd;
	ttp_pkg::count_t    cd_dec;
	logic               cd_zero;
	logic               cd_we;
	ttp_pkg::count_t    cd_wdata;
	logic               dl_less;
	logic               fire;
	logic               ran_n;
	logic               in_acc;
	logic               cfg_we;
	ttp_pkg::reg_idx_t  cfg_idx;

	assign pready    = 1'b1;
	assign in_ready  = (state_q == ttp_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign ran       = ran_q;
	assign task_index = task_idx_q;

	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = ttp_pkg::reg_idx_t'(paddr[ADDR_MSB:2]);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ttp_pkg::TASKS; i++) begin
				deadline_q[i] <= '0;
				reload_q[i]   <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				ttp_pkg::REG_DL0: deadline_q[0] <= pwdata[ttp_pkg::CFG_W-1:0];
				ttp_pkg::REG_DL1: deadline_q[1] <= pwdata[ttp_pkg::CFG_W-1:0];
				ttp_pkg::REG_DL2: deadline_q[2] <= pwdata[ttp_pkg::CFG_W-1:0];
				ttp_pkg::REG_RL0: reload_q[0]   <= pwdata[ttp_pkg::CFG_W-1:0];
				ttp_pkg::REG_RL1: reload_q[1]   <= pwdata[ttp_pkg::CFG_W-1:0];
				ttp_pkg::REG_RL2: reload_q[2]   <= pwdata[ttp_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			ttp_pkg::REG_DL0: prdata = {{(ttp_pkg::DATA_W-ttp_pkg::CFG_W){1'b0}}, deadline_q[0]};
			ttp_pkg::REG_DL1: prdata = {{(ttp_pkg::DATA_W-ttp_pkg::CFG_W){1'b0}}, deadline_q[1]};
			ttp_pkg::REG_DL2: prdata = {{(ttp_pkg::DATA_W-ttp_pkg::CFG_W){1'b0}}, deadline_q[2]};
			ttp_pkg::REG_RL0: prdata = {{(ttp_pkg::DATA_W-ttp_pkg::CFG_W){1'b0}}, reload_q[0]};
			ttp_pkg::REG_RL1: prdata = {{(ttp_pkg::DATA_W-ttp_pkg::CFG_W){1'b0}}, reload_q[1]};
			ttp_pkg::REG_RL2: prdata = {{(ttp_pkg::DATA_W-ttp_pkg::CFG_W){1'b0}}, reload_q[2]};
			default: prdata = '0;
		endcase
	end

	// shared unit: one cooldown read port, decrement, zero test, deadline compare
	assign cd_rd   = cd_q[cd_addr];
	assign cd_dec  = cd_rd - ttp_pkg::count_t'(1);
	assign cd_zero = (cd_rd == '0);
	assign dl_less = (win_dl_q > deadline_q[ch_q]);

	always_comb begin
		state_n  = state_q;
		win_n    = win_q;
		ch_n     = ch_q;
		win_dl_n = win_dl_q;
		cd_addr  = win_q;
		cd_we    = 1'b0;
		cd_wdata = cd_dec;
		fire     = 1'b0;
		ran_n    = 1'b0;
		unique case (state_q)
			ttp_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_n  = ttp_pkg::ST_WIN;
					win_n    = '0;
					ch_n     = ttp_pkg::task_idx_t'(1);
					win_dl_n = deadline_q[0];
				end
			end
			ttp_pkg::ST_WIN: begin
				// winner on cooldown: decrement it and hand the place to the challenger
				cd_addr = win_q;
				if (!cd_zero) begin
					cd_we    = 1'b1;
					win_n    = ch_q;
					win_dl_n = deadline_q[ch_q];
					if (ch_q == ttp_pkg::task_idx_t'(ttp_pkg::TASKS - 1)) begin
						state_n = ttp_pkg::ST_DISP;
					end else begin
						ch_n = ch_q + ttp_pkg::task_idx_t'(1);
					end
				end else begin
					state_n = ttp_pkg::ST_CHAL;
				end
			end
			ttp_pkg::ST_CHAL: begin
				cd_addr = ch_q;
				if (!cd_zero) begin
					cd_we = 1'b1;
				end else if (!mask_q[win_q] || (mask_q[ch_q] && dl_less)) begin
					win_n    = ch_q;
					win_dl_n = deadline_q[ch_q];
				end
				if (ch_q == ttp_pkg::task_idx_t'(ttp_pkg::TASKS - 1)) begin
					state_n = ttp_pkg::ST_DISP;
				end else begin
					ch_n    = ch_q + ttp_pkg::task_idx_t'(1);
					state_n = ttp_pkg::ST_WIN;
				end
			end
			ttp_pkg::ST_DISP: begin
				cd_addr  = win_q;
				cd_wdata = reload_q[win_q];
				ran_n    = mask_q[win_q] && cd_zero;
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					fire    = 1'b1;
					cd_we   = ran_n;
					state_n = ttp_pkg::ST_IDLE;
				end
			end
			default: state_n = ttp_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ttp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ttp_pkg::TASKS; i++) begin
				cd_q[i] <= '0;
			end
		end else if (cd_we) begin
			cd_q[cd_addr] <= cd_wdata;
		end
	end

	always_ff @(posedge clk) begin
		win_q    <= win_n;
		ch_q     <= ch_n;
		win_dl_q <= win_dl_n;
		if (in_acc) begin
			mask_q <= ready_mask;
		end
		if (fire) begin
			ran_q      <= ran_n;
			task_idx_q <= win_q;
		end
	end

endmodule

### hw/rtl/ttp_checker.sv
// port-level checks for tick_task_picker_core, attached by bind
// depends on ttp_pkg
`timescale 1ns / 1ps

module ttp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pready,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          ran,
	input logic [ttp_pkg::TASK_W-1:0]    task_index
);

	// a taken tick keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after an input beat");

	// a new result only appears while the sequencer was busy
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result beat without work in progress");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (task_index != 2'd3))
		else $error("task_index out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(ran) && $stable(task_index)))
		else $error("stalled result beat changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind tick_task_picker_core ttp_checker u_ttp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pready     (pready),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.ran        (ran),
	.task_index (task_index)
);
